FILE: rtl/cxa_pkg.sv
// Shared types and constants for the col2im accumulator.
// Used by the front, queue, back and top modules; depends on nothing.
package cxa_pkg;

    localparam int unsigned IMAGE_WORDS_DEF = 65536;
    localparam int unsigned VALUE_BITS_DEF  = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned ADDR_W          = 20;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PUSH  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_CHANNELS    = 3'd0,
        REG_IMAGE_SIZE  = 3'd1,
        REG_COL_SIZE    = 3'd2,
        REG_KERNEL_SIZE = 3'd3,
        REG_PADDING     = 3'd4,
        REG_STRIDE      = 3'd5,
        REG_DILATION    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ADD,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_GEOM,
        F_MUL1,
        F_MUL2,
        F_ISSUE
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_ADD,
        B_READ
    } back_state_t;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] column_value;
        logic [15:0]        read_index;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] image_value;
        logic [15:0]        image_index;
        logic               columns_complete;
        logic               dropped_flag;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  channels;
        logic [15:0] image_size;
        logic [15:0] col_size;
        logic [7:0]  kernel_size;
        logic [7:0]  padding;
        logic [7:0]  stride;
        logic [7:0]  dilation;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] value;
        logic [15:0]        index;
        logic               in_range;
        logic               complete;
        logic               dropped;
    } cmd_t;

endpackage

FILE: rtl/cxa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cxa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/cxa_queue.sv
// Short command queue between the front and the back of the accumulator.
// Depends on cxa_pkg.
module cxa_queue #(
    parameter int unsigned DEPTH = cxa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cxa_pkg::cmd_t push_cmd,
    input  logic          pop,
    output cxa_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cxa_pkg::cmd_t  entries [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/cxa_front.sv
// Front of the accumulator: takes requests, keeps the column position counters
// and status marks, computes image addresses and issues commands. Depends on cxa_pkg.
module cxa_front #(
    parameter int unsigned IMAGE_WORDS = cxa_pkg::IMAGE_WORDS_DEF,
    parameter int unsigned VALUE_BITS  = cxa_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cxa_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  cxa_pkg::in_item_t in_data,
    output logic             cmd_push,
    output cxa_pkg::cmd_t    cmd_out,
    input  logic             cmd_full
);

    localparam int unsigned SHIFT = 32 - VALUE_BITS;

    cxa_pkg::front_state_t state_reg, state_next;
    logic [3:0]  kcol_reg, kcol_next;
    logic [3:0]  krow_reg, krow_next;
    logic [7:0]  chan_reg, chan_next;
    logic [7:0]  grow_reg, grow_next;
    logic [7:0]  gcol_reg, gcol_next;
    logic        done_reg, done_next;
    logic        dropped_reg, dropped_next;

    cxa_pkg::cmd_t cmd_reg, cmd_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  ch_reg, ch_next;
    logic [16:0] lin_reg, lin_next;
    logic [24:0] idx_reg, idx_next;

    logic [7:0]  img_h, img_w;
    logic        nothing_expected, complete;
    logic [31:0] raw, shifted;
    logic signed [31:0] value;
    logic [14:0] row_c, col_c;
    logic        in_bounds, too_big;
    logic        c0, c1, c2, c3;

    assign img_h = cfg.image_size[15:8];
    assign img_w = cfg.image_size[7:0];
    assign nothing_expected = (cfg.channels == '0) || (cfg.col_size[15:8] == '0) ||
        (cfg.col_size[7:0] == '0) || (cfg.kernel_size[7:4] == '0) ||
        (cfg.kernel_size[3:0] == '0);
    assign complete = done_reg || nothing_expected;

    assign raw     = {16'b0, in_data.column_value};
    assign shifted = raw << SHIFT;
    assign value   = $signed(shifted) >>> SHIFT;

    assign row_c = 15'(grow_reg * cfg.stride[7:4]) + 15'(krow_reg * cfg.dilation[7:4])
        - 15'(cfg.padding[7:4]);
    assign col_c = 15'(gcol_reg * cfg.stride[3:0]) + 15'(kcol_reg * cfg.dilation[3:0])
        - 15'(cfg.padding[3:0]);
    assign in_bounds = !row_c[14] && (row_c[13:0] < 14'(img_h)) &&
        !col_c[14] && (col_c[13:0] < 14'(img_w));
    assign too_big = (32'(idx_reg) >= 32'(IMAGE_WORDS));

    assign in_stall = (state_reg != cxa_pkg::F_IDLE);
    assign cmd_out  = cmd_reg;

    assign c0 = (9'(gcol_reg) + 9'd1 >= 9'(cfg.col_size[7:0]));
    assign c1 = (9'(grow_reg) + 9'd1 >= 9'(cfg.col_size[15:8]));
    assign c2 = (5'(kcol_reg) + 5'd1 >= 5'(cfg.kernel_size[3:0]));
    assign c3 = (5'(krow_reg) + 5'd1 >= 5'(cfg.kernel_size[7:4]));

    always_comb
    begin
        state_next   = state_reg;
        kcol_next    = kcol_reg;
        krow_next    = krow_reg;
        chan_next    = chan_reg;
        grow_next    = grow_reg;
        gcol_next    = gcol_reg;
        done_next    = done_reg;
        dropped_next = dropped_reg;
        cmd_next     = cmd_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        ch_next      = ch_reg;
        lin_next     = lin_reg;
        idx_next     = idx_reg;
        cmd_push     = 1'b0;

        case (state_reg)
            cxa_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.operation)
                        cxa_pkg::OP_START:
                        begin
                            kcol_next     = '0;
                            krow_next     = '0;
                            chan_next     = '0;
                            grow_next     = '0;
                            gcol_next     = '0;
                            done_next     = 1'b0;
                            dropped_next  = 1'b0;
                            cmd_next      = '0;
                            cmd_next.kind = cxa_pkg::CMD_CLEAR;
                            state_next    = cxa_pkg::F_ISSUE;
                        end
                        cxa_pkg::OP_PUSH:
                        begin
                            if (complete)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                cmd_next       = '0;
                                cmd_next.kind  = cxa_pkg::CMD_ADD;
                                cmd_next.value = value;
                                state_next     = cxa_pkg::F_GEOM;
                            end
                        end
                        cxa_pkg::OP_READ:
                        begin
                            cmd_next          = '0;
                            cmd_next.kind     = cxa_pkg::CMD_READ;
                            cmd_next.addr     = cxa_pkg::ADDR_W'(in_data.read_index);
                            cmd_next.index    = in_data.read_index;
                            cmd_next.in_range =
                                (32'(in_data.read_index) < 32'(IMAGE_WORDS));
                            cmd_next.complete = complete;
                            cmd_next.dropped  = dropped_reg;
                            state_next        = cxa_pkg::F_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cxa_pkg::F_GEOM:
            begin
                row_next = row_c[7:0];
                col_next = col_c[7:0];
                ch_next  = chan_reg;
                gcol_next = c0 ? '0 : gcol_reg + 1'b1;
                if (c0)
                begin
                    grow_next = c1 ? '0 : grow_reg + 1'b1;
                    if (c1)
                    begin
                        kcol_next = c2 ? '0 : kcol_reg + 1'b1;
                        if (c2)
                        begin
                            krow_next = c3 ? '0 : krow_reg + 1'b1;
                            if (c3)
                            begin
                                if (9'(chan_reg) + 9'd1 >= 9'(cfg.channels))
                                begin
                                    chan_next = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    chan_next = chan_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                state_next = in_bounds ? cxa_pkg::F_MUL1 : cxa_pkg::F_IDLE;
            end
            cxa_pkg::F_MUL1:
            begin
                lin_next   = 17'(ch_reg * img_h) + 17'(row_reg);
                state_next = cxa_pkg::F_MUL2;
            end
            cxa_pkg::F_MUL2:
            begin
                idx_next      = 25'(lin_reg * img_w) + 25'(col_reg);
                cmd_next.addr = cxa_pkg::ADDR_W'(idx_next);
                state_next    = cxa_pkg::F_ISSUE;
            end
            cxa_pkg::F_ISSUE:
            begin
                if (cmd_reg.kind == cxa_pkg::CMD_ADD && too_big)
                begin
                    dropped_next = 1'b1;
                    state_next   = cxa_pkg::F_IDLE;
                end
                else if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = cxa_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = cxa_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cxa_pkg::F_IDLE;
            kcol_reg    <= '0;
            krow_reg    <= '0;
            chan_reg    <= '0;
            grow_reg    <= '0;
            gcol_reg    <= '0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kcol_reg    <= kcol_next;
            krow_reg    <= krow_next;
            chan_reg    <= chan_next;
            grow_reg    <= grow_next;
            gcol_reg    <= gcol_next;
            done_reg    <= done_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        row_reg <= row_next;
        col_reg <= col_next;
        ch_reg  <= ch_next;
        lin_reg <= lin_next;
        idx_reg <= idx_next;
    end

endmodule

FILE: rtl/cxa_back.sv
// Back of the accumulator: executes clear, add and read commands against the
// image store and holds the result register. Depends on cxa_pkg and cxa_ram.
module cxa_back #(
    parameter int unsigned IMAGE_WORDS = cxa_pkg::IMAGE_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cxa_pkg::cmd_t     head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output cxa_pkg::out_item_t out_data
);

    localparam int unsigned AW = $clog2(IMAGE_WORDS);

    cxa_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    cxa_pkg::cmd_t      cmd_reg, cmd_next;
    logic               out_valid_reg, out_valid_next;
    cxa_pkg::out_item_t out_reg, out_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;
    logic signed [32:0] sum;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign sum = 33'($signed(ram_rdata)) + 33'(cmd_reg.value);

    cxa_ram #(
        .WIDTH (32),
        .DEPTH (IMAGE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cmd_reg.addr[AW-1:0];
        ram_wdata      = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cxa_pkg::B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(IMAGE_WORDS - 1))
                begin
                    state_next = cxa_pkg::B_IDLE;
                end
            end
            cxa_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    cmd_next = head;
                    case (head.kind)
                        cxa_pkg::CMD_CLEAR:
                        begin
                            pop        = 1'b1;
                            clr_next   = '0;
                            state_next = cxa_pkg::B_CLEAR;
                        end
                        cxa_pkg::CMD_ADD:
                        begin
                            pop        = 1'b1;
                            state_next = cxa_pkg::B_ADD;
                        end
                        cxa_pkg::CMD_READ:
                        begin
                            if (!out_valid_reg || !out_stall)
                            begin
                                pop        = 1'b1;
                                state_next = cxa_pkg::B_READ;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            cxa_pkg::B_ADD:
            begin
                ram_we = 1'b1;
                if (sum > 33'sh0_7FFF_FFFF)
                begin
                    ram_wdata = 32'h7FFF_FFFF;
                end
                else if (sum < -33'sh0_8000_0000)
                begin
                    ram_wdata = 32'h8000_0000;
                end
                else
                begin
                    ram_wdata = sum[31:0];
                end
                state_next = cxa_pkg::B_IDLE;
            end
            cxa_pkg::B_READ:
            begin
                out_valid_next            = 1'b1;
                out_next.image_value      = cmd_reg.in_range ? $signed(ram_rdata) : '0;
                out_next.image_index      = cmd_reg.index;
                out_next.columns_complete = cmd_reg.complete;
                out_next.dropped_flag     = cmd_reg.dropped;
                state_next                = cxa_pkg::B_IDLE;
            end
            default:
            begin
                state_next = cxa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cxa_pkg::B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

FILE: rtl/col2im_accumulator_top.sv
// Top level of the col2im accumulator: configuration registers, front, queue, back.
// Depends on cxa_pkg, cxa_front, cxa_queue, cxa_back and cxa_ram.
//
// The block scatters column values into an image store and sums overlaps with
// 32-bit saturation. A push request passes through the front's states in order
// (accept, location, two multiplies for the flat index, issue), a read passes
// through accept and issue in the front and through idle and read in the back,
// and each store update in the back is a read-modify-write of the single image
// RAM. After reset and after every start request the back clears the store one
// word per cycle, all IMAGE_WORDS words, while requests wait in the queue.
// Configuration writes are always taken and belong only to idle periods.
module col2im_accumulator_top #(
    parameter int unsigned IMAGE_WORDS = cxa_pkg::IMAGE_WORDS_DEF,
    parameter int unsigned VALUE_BITS  = cxa_pkg::VALUE_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = cxa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cxa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cxa_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cxa_pkg::cfg_t cfg_reg, cfg_next;
    cxa_pkg::cmd_t q_in, q_head;
    logic          q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cxa_pkg::REG_CHANNELS:    cfg_next.channels    = cfg_data[7:0];
                cxa_pkg::REG_IMAGE_SIZE:  cfg_next.image_size  = cfg_data;
                cxa_pkg::REG_COL_SIZE:    cfg_next.col_size    = cfg_data;
                cxa_pkg::REG_KERNEL_SIZE: cfg_next.kernel_size = cfg_data[7:0];
                cxa_pkg::REG_PADDING:     cfg_next.padding     = cfg_data[7:0];
                cxa_pkg::REG_STRIDE:      cfg_next.stride      = cfg_data[7:0];
                cxa_pkg::REG_DILATION:    cfg_next.dilation    = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channels    <= 8'd1;
            cfg_reg.image_size  <= 16'd257;
            cfg_reg.col_size    <= 16'd257;
            cfg_reg.kernel_size <= 8'd17;
            cfg_reg.padding     <= 8'd0;
            cfg_reg.stride      <= 8'd17;
            cfg_reg.dilation    <= 8'd17;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cxa_front #(
        .IMAGE_WORDS (IMAGE_WORDS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cmd_push (q_push),
        .cmd_out  (q_in),
        .cmd_full (q_full)
    );

    cxa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    cxa_back #(
        .IMAGE_WORDS (IMAGE_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.kind == cxa_pkg::CMD_READ) |=> ##1 out_valid)
        else $error("read command produced no result");
`endif

endmodule
